/* hdl/m4rm_pkg.sv */
package m4rm_pkg;

  localparam int DIM          = 4;
  localparam int ELEM_W       = 32;
  localparam int IDX_W        = 2;
  localparam int ADDR_W       = 2 * IDX_W;
  localparam int PROD_W       = 2 * ELEM_W;
  // four products summed at full precision need two more bits
  localparam int SUM_W        = PROD_W + 2;
  localparam int FRAC_BITS_DEF = 16;
  localparam int TDATA_W      = ((IDX_W + DIM * ELEM_W + 7) / 8) * 8;

  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_MULTIPLY = 1'b1;

  localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  // pipeline stage load enables, one per register stage of a column
  typedef struct packed {
    logic mul;
    logic sum;
    logic sat;
  } stage_en_t;

endpackage

/* hdl/m4rm_column.sv */
module m4rm_column #(
  parameter int FRAC_BITS = m4rm_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  m4rm_pkg::stage_en_t                  en_i,
  input  logic signed [m4rm_pkg::ELEM_W-1:0]   a_i [m4rm_pkg::DIM],
  input  logic signed [m4rm_pkg::ELEM_W-1:0]   b_i [m4rm_pkg::DIM],
  output logic signed [m4rm_pkg::ELEM_W-1:0]   res_o,
  output logic                                 sat_o
);

  localparam int EW = m4rm_pkg::ELEM_W;
  localparam int PW = m4rm_pkg::PROD_W;
  localparam int SW = m4rm_pkg::SUM_W;

  logic signed [PW-1:0] prod_d [m4rm_pkg::DIM];
  logic signed [PW-1:0] prod_q [m4rm_pkg::DIM];
  logic signed [SW-1:0] sum_d;
  logic signed [SW-1:0] sum_q;
  logic signed [SW-1:0] shifted;
  logic [SW-EW:0]       hi_bits;
  logic signed [EW-1:0] res_d;
  logic signed [EW-1:0] res_q;
  logic                 sat_d;
  logic                 sat_q;

  always_comb begin
    for (int k = 0; k < m4rm_pkg::DIM; k++) begin
      prod_d[k] = PW'(a_i[k]) * PW'(b_i[k]);
    end
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < m4rm_pkg::DIM; k++) begin
      sum_d = sum_d + SW'(prod_q[k]);
    end
  end

  // floor shift, then clip whatever does not fit in one element
  always_comb begin
    shifted = sum_q >>> FRAC_BITS;
    hi_bits = shifted[SW-1:EW-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      res_d = shifted[EW-1:0];
      sat_d = 1'b0;
    end else if (shifted[SW-1]) begin
      res_d = m4rm_pkg::ELEM_MIN;
      sat_d = 1'b1;
    end else begin
      res_d = m4rm_pkg::ELEM_MAX;
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      prod_q <= prod_d;
    end
    if (en_i.sum) begin
      sum_q <= sum_d;
    end
    if (en_i.sat) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

/* hdl/matrix4_row_multiply.sv */
// 4x4 matrix row multiplier, signed Q16.16 (fraction width set by FRAC_BITS).
// Input stream: tuser[0] selects the command. A load beat writes one row of
// the right matrix B; a multiply beat carries one row of the left matrix A
// and produces one output beat with that row of A times B.
// Output stream: tdata holds the row number and four product elements,
// tuser[0] flags that at least one element was saturated.
// Each element is the full-precision dot product, shifted right with floor
// rounding and clipped to 32 bits.
// Throughput: one beat per cycle, loads and multiplies in any mix, unless a
// receiver stall fills the pipeline. A load takes effect for the next beat,
// so a multiply right behind it sees it. A multiply beat passes through the
// multiply, sum and shift/saturate stages, all registered, and is held in
// the last stage only while the receiver stalls.
// A stall holds the output beat; empty stages behind it keep filling, and
// s_axis_tready drops only once all three stages are occupied.
// Reset clears the B store to zero and empties the pipeline.
module matrix4_row_multiply #(
  parameter int FRAC_BITS = m4rm_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // row_index [1:0], elem_0 [33:2], elem_1 [65:34], elem_2 [97:66],
  // elem_3 [129:98], zero pad above
  input  logic [m4rm_pkg::TDATA_W-1:0]  s_axis_tdata,
  // command [0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_row [1:0], prod_0 [33:2], prod_1 [65:34], prod_2 [97:66],
  // prod_3 [129:98], zero pad above
  output logic [m4rm_pkg::TDATA_W-1:0]  m_axis_tdata,
  // saturated [0]
  output logic                          m_axis_tuser
);

  localparam int DIM = m4rm_pkg::DIM;
  localparam int EW  = m4rm_pkg::ELEM_W;
  localparam int IW  = m4rm_pkg::IDX_W;

  logic                 accept;
  logic                 load_acc;
  logic                 mul_acc;
  logic [IW-1:0]        row_in;
  logic signed [EW-1:0] elem [DIM];
  logic signed [EW-1:0] b_q [DIM*DIM];
  logic signed [EW-1:0] b_col [DIM][DIM];
  logic signed [EW-1:0] res [DIM];
  logic [DIM-1:0]       sat;

  logic          adv1, adv2, adv3;
  logic          v1_q, v2_q, v3_q;
  logic [IW-1:0] row1_q, row2_q, row3_q;
  m4rm_pkg::stage_en_t en;

  always_comb begin
    row_in = s_axis_tdata[IW-1:0];
    for (int k = 0; k < DIM; k++) begin
      elem[k] = s_axis_tdata[IW + k*EW +: EW];
    end
  end

  // advance a stage when it is empty or the one ahead moves on
  assign adv3 = !v3_q || m_axis_tready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign s_axis_tready = adv1;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign load_acc = accept && (s_axis_tuser == m4rm_pkg::CMD_LOAD);
  assign mul_acc  = accept && (s_axis_tuser == m4rm_pkg::CMD_MULTIPLY);

  assign en = '{mul: adv1, sum: adv2, sat: adv3};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIM*DIM; i++) begin
        b_q[i] <= '0;
      end
    end else if (load_acc) begin
      for (int i = 0; i < DIM*DIM; i++) begin
        if (row_in == IW'(i / DIM)) begin
          b_q[i] <= elem[i % DIM];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= mul_acc;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) row1_q <= row_in;
    if (adv2) row2_q <= row1_q;
    if (adv3) row3_q <= row2_q;
  end

  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      for (int k = 0; k < DIM; k++) begin
        b_col[j][k] = b_q[k*DIM + j];
      end
    end
  end

  for (genvar j = 0; j < DIM; j++) begin : g_col
    m4rm_column #(
      .FRAC_BITS(FRAC_BITS)
    ) u_col (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (elem),
      .b_i   (b_col[j]),
      .res_o (res[j]),
      .sat_o (sat[j])
    );
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[IW-1:0] = row3_q;
    for (int j = 0; j < DIM; j++) begin
      m_axis_tdata[IW + j*EW +: EW] = res[j];
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tuser  = |sat;

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_acc |=> !v1_q)
    else $error("load beat entered the result pipeline");

  a_mul_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_acc |=> v1_q)
    else $error("multiply beat lost at the first stage");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while the pipeline is full and stalled");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (res[0] == m4rm_pkg::ELEM_MAX || res[0] == m4rm_pkg::ELEM_MIN ||
       res[1] == m4rm_pkg::ELEM_MAX || res[1] == m4rm_pkg::ELEM_MIN ||
       res[2] == m4rm_pkg::ELEM_MAX || res[2] == m4rm_pkg::ELEM_MIN ||
       res[3] == m4rm_pkg::ELEM_MAX || res[3] == m4rm_pkg::ELEM_MIN))
    else $error("saturation flag without a clipped element");

endmodule

/* tb/sv/tb_matrix4_row_multiply.sv */
`timescale 1ns / 1ps

module tb_matrix4_row_multiply;

  localparam int DIM           = m4rm_pkg::DIM;
  localparam int ELEM_W        = m4rm_pkg::ELEM_W;
  localparam int IDX_W         = m4rm_pkg::IDX_W;
  localparam int SUM_W         = m4rm_pkg::SUM_W;
  localparam int TDATA_W       = m4rm_pkg::TDATA_W;
  localparam int FRAC_BITS_DEF = m4rm_pkg::FRAC_BITS_DEF;

  localparam logic CMD_LOAD     = m4rm_pkg::CMD_LOAD;
  localparam logic CMD_MULTIPLY = m4rm_pkg::CMD_MULTIPLY;
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = m4rm_pkg::ELEM_MAX;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = m4rm_pkg::ELEM_MIN;

  localparam int LIMIT_CYCLES    = 400000;
  localparam int NUM_RANDOM      = 1000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int PAD_W           = TDATA_W - IDX_W - DIM * ELEM_W;

  localparam logic [ELEM_W-1:0] Q_ONE    = 32'h0001_0000;
  localparam logic [ELEM_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MAX = 66'sd2147483647;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -66'sd2147483648;

  typedef logic [DIM-1:0][ELEM_W-1:0] elem_row_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    elem_row_t        prod;
    logic             sat;
  } product_row_t;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] row;
    elem_row_t        elems;
    logic             has_gold;
    product_row_t     gold;
  } row_beat_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic               s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tuser;

  // shadow of the B store, row-major
  logic [ELEM_W-1:0] b_rows [DIM*DIM];
  product_row_t      pending_rows [$];
  row_beat_t         dir_table [$];
  int                errors = 0;
  int                cycles = 0;
  bit                calm = 0;
  bit                hold_req = 0;

  matrix4_row_multiply uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic product_row_t multiply_by_b(logic [IDX_W-1:0] row, elem_row_t a);
    product_row_t           r;
    logic signed [SUM_W-1:0] acc;
    r.row = row;
    r.sat = 1'b0;
    for (int c = 0; c < DIM; c++) begin
      acc = '0;
      for (int k = 0; k < DIM; k++)
        acc = acc + $signed(a[k]) * $signed(b_rows[k*DIM+c]);
      acc = acc >>> FRAC_BITS_DEF;
      if (acc > SUM_MAX) begin
        r.prod[c] = ELEM_MAX;
        r.sat     = 1'b1;
      end else if (acc < SUM_MIN) begin
        r.prod[c] = ELEM_MIN;
        r.sat     = 1'b1;
      end else begin
        r.prod[c] = acc[ELEM_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic row_beat_t row_beat(logic cmd, logic [IDX_W-1:0] row,
                                         logic [ELEM_W-1:0] e0, logic [ELEM_W-1:0] e1,
                                         logic [ELEM_W-1:0] e2, logic [ELEM_W-1:0] e3);
    row_beat_t b;
    b.cmd      = cmd;
    b.row      = row;
    b.elems    = {e3, e2, e1, e0};
    b.has_gold = 1'b0;
    b.gold     = '0;
    return b;
  endfunction

  function automatic row_beat_t known_product(logic [IDX_W-1:0] row,
      logic [ELEM_W-1:0] e0, logic [ELEM_W-1:0] e1, logic [ELEM_W-1:0] e2,
      logic [ELEM_W-1:0] e3, logic [ELEM_W-1:0] p0, logic [ELEM_W-1:0] p1,
      logic [ELEM_W-1:0] p2, logic [ELEM_W-1:0] p3, logic sat);
    row_beat_t b;
    b            = row_beat(CMD_MULTIPLY, row, e0, e1, e2, e3);
    b.has_gold   = 1'b1;
    b.gold.row   = row;
    b.gold.prod  = {p3, p2, p1, p0};
    b.gold.sat   = sat;
    return b;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [ELEM_W-1:0] pick_elem();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3)
      return $urandom_range(0, 8) * 32'h8000 - 32'h2_0000;
    if (r == 3) begin
      case ($urandom_range(0, 5))
        0:       return ELEM_MAX;
        1:       return ELEM_MIN;
        2:       return '0;
        3:       return ALL_ONES;
        4:       return 32'h1;
        default: return Q_ONE;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_beat(row_beat_t b);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = TDATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
      s_axis_tuser  = 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = b.cmd;
    s_axis_tdata  = {{PAD_W{1'b0}}, b.elems, b.row};
    do @(posedge clk_i); while (!s_axis_tready);
    if (b.cmd == CMD_LOAD) begin
      for (int j = 0; j < DIM; j++)
        b_rows[b.row*DIM+j] = b.elems[j];
    end else if (b.has_gold) begin
      pending_rows.push_back(b.gold);
    end else begin
      pending_rows.push_back(multiply_by_b(b.row, b.elems));
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !held) begin
        gap  = HOLD_OFF_CYCLES;
        held = 1'b1;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    product_row_t got;
    product_row_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.row = m_axis_tdata[IDX_W-1:0];
      for (int i = 0; i < DIM; i++)
        got.prod[i] = m_axis_tdata[IDX_W+i*ELEM_W +: ELEM_W];
      got.sat = m_axis_tuser;
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected product beat, got row %0d %h sat %0b",
                 $time, got.row, got.prod, got.sat);
        errors++;
      end else begin
        want = pending_rows.pop_front();
        if (got.row != want.row) begin
          $display("%0t: out_row expected %0d got %0d", $time, want.row, got.row);
          errors++;
        end
        for (int i = 0; i < DIM; i++) begin
          if (got.prod[i] != want.prod[i]) begin
            $display("%0t: prod_%0d expected %h got %h", $time, i, want.prod[i], got.prod[i]);
            errors++;
          end
        end
        if (got.sat != want.sat) begin
          $display("%0t: saturated expected %0b got %0b", $time, want.sat, got.sat);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    row_beat_t b;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_LOAD;
    for (int i = 0; i < DIM*DIM; i++)
      b_rows[i] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    dir_table = '{
      // B store is still clear after reset
      known_product(2'd2, ELEM_MAX, ELEM_MIN, ALL_ONES, Q_ONE, '0, '0, '0, '0, 1'b0),
      // identity B passes the A row through
      row_beat(CMD_LOAD, 2'd0, Q_ONE, '0, '0, '0),
      row_beat(CMD_LOAD, 2'd1, '0, Q_ONE, '0, '0),
      row_beat(CMD_LOAD, 2'd2, '0, '0, Q_ONE, '0),
      row_beat(CMD_LOAD, 2'd3, '0, '0, '0, Q_ONE),
      known_product(2'd1, ELEM_MAX, ELEM_MIN, 32'h1, ALL_ONES,
                    ELEM_MAX, ELEM_MIN, 32'h1, ALL_ONES, 1'b0),
      known_product(2'd0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0),
      row_beat(CMD_MULTIPLY, 2'd3, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F,
               32'hF0F0_F0F0),
      // smallest step in row 0: the shift floors toward minus infinity
      row_beat(CMD_LOAD, 2'd0, 32'h1, 32'h1, 32'h1, 32'h1),
      known_product(2'd0, ALL_ONES, '0, '0, '0, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                    1'b0),
      known_product(2'd2, 32'h1, '0, '0, '0, '0, '0, '0, '0, 1'b0),
      // single products that clip both ways
      row_beat(CMD_LOAD, 2'd0, ELEM_MAX, ELEM_MIN, ELEM_MAX, Q_ONE),
      known_product(2'd1, ELEM_MAX, '0, '0, '0, ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MAX,
                    1'b1),
      // all of B at the negative extreme: the sum needs the full width
      row_beat(CMD_LOAD, 2'd0, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN),
      row_beat(CMD_LOAD, 2'd1, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN),
      row_beat(CMD_LOAD, 2'd2, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN),
      row_beat(CMD_LOAD, 2'd3, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN),
      known_product(2'd3, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN,
                    ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, 1'b1),
      known_product(2'd0, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX,
                    ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN, 1'b1),
      row_beat(CMD_MULTIPLY, 2'd2, ELEM_MIN, ELEM_MAX, '0, ALL_ONES),
      // load then a multiply as the next beat, possibly after a random gap
      row_beat(CMD_LOAD, 2'd1, 32'h0002_0000, ALL_ONES, 32'h7FFF_0000, 32'h8000_8000),
      row_beat(CMD_MULTIPLY, 2'd1, 32'h0003_0000, 32'h0000_8000, ALL_ONES, 32'hFFFE_0000)
    };
    foreach (dir_table[i])
      send_beat(dir_table[i]);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      calm = (n >= 600 && n < 700);
      // long receiver hold-off while beats keep coming
      if (n == 300)
        hold_req = 1'b1;
      b.cmd = ($urandom_range(0, 9) < 3) ? CMD_LOAD : CMD_MULTIPLY;
      b.row = IDX_W'($urandom_range(0, DIM - 1));
      for (int j = 0; j < DIM; j++)
        b.elems[j] = pick_elem();
      b.has_gold = 1'b0;
      b.gold     = '0;
      send_beat(b);
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_rows.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
